>>> rtl/iccs_pkg.sv
// Package: shared constants, item types and the matcher stage code for the ICC signature scanner.
package iccs_pkg;

  // Default width of the byte position counters.
  localparam int POSITION_BITS_DEF = 32;

  // Signature bytes "acsp".
  localparam logic [7:0] SIG_A = 8'h61;
  localparam logic [7:0] SIG_C = 8'h63;
  localparam logic [7:0] SIG_S = 8'h73;
  localparam logic [7:0] SIG_P = 8'h70;

  // Header geometry: the header starts HEADER_BACK - 1 bytes before the 'p'.
  localparam int HEADER_BACK = 40;
  localparam int HISTORY_LEN = HEADER_BACK - 1;
  localparam int HEADER_LEN  = 128;

  // Matcher stage: number of signature bytes seen so far.
  typedef enum logic [1:0] {
    STG_NONE = 2'd0,
    STG_A    = 2'd1,
    STG_AC   = 2'd2,
    STG_ACS  = 2'd3
  } stage_t;

  // One input item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic        profile_found;
    logic [31:0] profile_offset;
    logic [31:0] profile_size;
  } out_item_t;

  // Matcher advance for a byte that does not complete the signature.
  // A byte 'a' always restarts at stage one, so overlaps are kept.
  function automatic stage_t next_stage(input stage_t stage, input logic [7:0] b);
    stage_t restart;
    restart = (b == SIG_A) ? STG_A : STG_NONE;
    case (stage)
      STG_NONE: next_stage = restart;
      STG_A:    next_stage = (b == SIG_C) ? STG_AC : restart;
      STG_AC:   next_stage = (b == SIG_S) ? STG_ACS : restart;
      STG_ACS:  next_stage = restart;
      default:  next_stage = STG_NONE;
    endcase
  endfunction

endpackage

>>> rtl/iccs_if.sv
// Interfaces: the byte input channel and the result channel of the scanner.
interface iccs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface iccs_out_if;
  logic        valid;
  logic        ready;
  logic        profile_found;
  logic [31:0] profile_offset;
  logic [31:0] profile_size;

  modport source (output valid, output profile_found, output profile_offset,
                  output profile_size, input ready);
  modport sink   (input valid, input profile_found, input profile_offset,
                  input profile_size, output ready);
endinterface

>>> rtl/iccs_in_reg.sv
// Input register: captures one byte transfer per cycle and holds it while the scan stalls.
module iccs_in_reg (
  input  logic             clk,
  input  logic             rst_n,
  iccs_in_if.sink          in_chan,
  input  logic             advance,
  output logic             item_valid,
  output iccs_pkg::in_item_t item
);
  import iccs_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     take;

  // A new byte may enter when the register is empty or drains this cycle.
  assign in_chan.ready = !valid_r || advance;
  assign take          = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      item_r.data_byte     <= in_chan.data_byte;
      item_r.end_of_stream <= in_chan.end_of_stream;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

>>> rtl/iccs_scan_core.sv
// Scan core: signature matcher, byte history, header capture and end-of-stream result.
module iccs_scan_core #(
  parameter int POSITION_BITS = iccs_pkg::POSITION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  iccs_pkg::in_item_t  item,
  output logic                res_valid,
  output iccs_pkg::out_item_t res
);
  import iccs_pkg::*;

  localparam logic [POSITION_BITS-1:0] EARLY_LIMIT = POSITION_BITS'(HISTORY_LEN);
  localparam logic [POSITION_BITS-1:0] RESUME_STEP = POSITION_BITS'(HEADER_LEN - HISTORY_LEN);
  localparam logic [31:0]              SIZE_MIN    = 32'(HEADER_LEN);

  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] resume_r, resume_nxt;
  logic [POSITION_BITS-1:0] offset_r, offset_nxt;
  logic [31:0]              size_r, size_nxt;
  logic                     stopped_r, stopped_nxt;
  stage_t                   stage_r, stage_nxt;
  logic [7:0]               hist_r [HISTORY_LEN];

  logic active;
  logic is_match;
  logic eos;

  assign eos      = item_valid && item.end_of_stream;
  assign active   = !stopped_r && (pos_r >= resume_r);
  assign is_match = active && (stage_r == STG_ACS) && (item.data_byte == SIG_P);

  // Matcher stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= STG_NONE;
    end else begin
      stage_r <= stage_nxt;
    end
  end

  // Next matcher stage, header capture and position update.
  always_comb begin
    stage_nxt   = stage_r;
    pos_nxt     = pos_r;
    resume_nxt  = resume_r;
    offset_nxt  = offset_r;
    size_nxt    = size_r;
    stopped_nxt = stopped_r;
    if (item_valid) begin
      pos_nxt = pos_r + 1'b1;
      if (is_match) begin
        stage_nxt = STG_NONE;
        if (pos_r < EARLY_LIMIT) begin
          // Header would start before the file: record offset zero and stop.
          offset_nxt  = '0;
          stopped_nxt = 1'b1;
        end else begin
          offset_nxt = pos_r - EARLY_LIMIT;
          size_nxt   = {hist_r[0], hist_r[1], hist_r[2], hist_r[3]};
          resume_nxt = pos_r + RESUME_STEP;
        end
      end else if (active) begin
        stage_nxt = next_stage(stage_r, item.data_byte);
      end
    end
    // Result for the final byte, taken after that byte is scanned.
    res_valid          = eos;
    res.profile_found  = (offset_nxt != '0) && (size_nxt > SIZE_MIN);
    res.profile_offset = 32'(offset_nxt);
    res.profile_size   = size_nxt;
    // End of stream returns everything to the reset state.
    if (eos) begin
      stage_nxt   = STG_NONE;
      pos_nxt     = '0;
      resume_nxt  = '0;
      offset_nxt  = '0;
      size_nxt    = '0;
      stopped_nxt = 1'b0;
    end
  end

  // Scan state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      resume_r  <= '0;
      offset_r  <= '0;
      size_r    <= '0;
      stopped_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      resume_r  <= resume_nxt;
      offset_r  <= offset_nxt;
      size_r    <= size_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  // Byte history, oldest at index zero; cleared at end of stream.
  always_ff @(posedge clk) begin
    if (!rst_n || eos) begin
      for (int i = 0; i < HISTORY_LEN; i++) begin
        hist_r[i] <= '0;
      end
    end else if (item_valid) begin
      for (int i = 0; i < HISTORY_LEN - 1; i++) begin
        hist_r[i] <= hist_r[i+1];
      end
      hist_r[HISTORY_LEN-1] <= item.data_byte;
    end
  end

  // After the final byte the position counter restarts at zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    eos |=> (pos_r == '0) && (stage_r == STG_NONE))
    else $error("scan state not cleared after end of stream");

  // Once matching has stopped the matcher rests at stage zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> (stage_r == STG_NONE))
    else $error("matcher advanced while stopped");

  // A kept header always carries its resume point one header length later.
  assert property (@(posedge clk) disable iff (!rst_n)
    (offset_r != '0) |-> (resume_r == offset_r + POSITION_BITS'(HEADER_LEN)))
    else $error("resume point does not follow kept header");

endmodule

>>> rtl/icc_profile_signature_scanner.sv
// Top level: embedded ICC profile header scanner, one file byte per cycle.
//
//   channel   direction  payload                                        width
//   in_chan   input      data_byte, end_of_stream                       8 + 1
//   out_chan  output     profile_found, profile_offset, profile_size    1 + 32 + 32
//
// A byte is held in the input register and the scan core updates its state from it
// at the next edge, so a new byte is taken every cycle while no final byte stalls. A result is
// loaded into the output register at the edge where its final byte leaves the input register.
// Reset is synchronous and active low and clears the whole scan state at once. Only a final
// byte, and the bytes behind it, stall while a result waits.
module icc_profile_signature_scanner #(
  parameter int POSITION_BITS = iccs_pkg::POSITION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  iccs_in_if.sink   in_chan,
  iccs_out_if.source out_chan
);
  import iccs_pkg::*;

  logic      item_valid;
  in_item_t  item;
  logic      advance;
  logic      res_valid;
  out_item_t res;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;

  // A final byte waits while the previous result is still held.
  assign advance = item_valid &&
                   !(item.end_of_stream && out_valid_r && !out_chan.ready);

  iccs_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  iccs_scan_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_scan_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (advance),
    .item       (item),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Output register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_item_r <= res;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.profile_found  = out_item_r.profile_found;
  assign out_chan.profile_offset = out_item_r.profile_offset;
  assign out_chan.profile_size   = out_item_r.profile_size;

  // A new result never overwrites one that has not been transferred.
  assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (!out_valid_r || out_chan.ready))
    else $error("result overwrote a pending result");

  // The output register fills only from a scanned final byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(advance && item.end_of_stream))
    else $error("result without a final byte");

endmodule
